// ----- hw/rtl/pfrc_pkg.sv -----
// pfrc_pkg: shared types, codes and constants of the port fuse retry controller.
// No dependencies; every other file of the block but pfrc_ram imports it.
package pfrc_pkg;

   localparam int NUM_PORTS_DEF = 8;
   localparam int MAX_PORTS     = 8;
   localparam int MAX_RESULTS   = 8;
   localparam int SETTLE_MS     = 2000;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_RETRY_LIMIT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RETRY_INTERVAL = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FUSE_OK_LEVELS = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE_AH      = 2'd3;

   localparam logic [7:0]  RETRY_LIMIT_RST    = 8'd0;
   localparam logic [15:0] RETRY_INTERVAL_RST = 16'd100;
   localparam logic [7:0]  FUSE_OK_LEVELS_RST = 8'd0;
   localparam logic [7:0]  ENABLE_AH_RST      = 8'hFF;

   localparam logic [2:0] OP_FAULT       = 3'd0;
   localparam logic [2:0] OP_TICK        = 3'd1;
   localparam logic [2:0] OP_ENABLE_ALL  = 3'd2;
   localparam logic [2:0] OP_DISABLE_ALL = 3'd3;
   localparam logic [2:0] OP_SET_PORT    = 3'd4;

   localparam logic [2:0] ACT_NONE          = 3'd0;
   localparam logic [2:0] ACT_FORCE_OFF     = 3'd1;
   localparam logic [2:0] ACT_RETRY_PULSE   = 3'd2;
   localparam logic [2:0] ACT_FAULT_WARNING = 3'd3;
   localparam logic [2:0] ACT_RETRY_CLEARED = 3'd4;
   localparam logic [2:0] ACT_DRIVE_SET     = 3'd5;
   localparam logic [2:0] ACT_ALL_ON        = 3'd6;
   localparam logic [2:0] ACT_ALL_OFF       = 3'd7;

   typedef struct packed {
      logic [2:0]  operation;
      logic [2:0]  port;
      logic        turn_on;
      logic [7:0]  fuse_levels;
      logic [31:0] now_ms;
   } pfrc_req_type;

   typedef struct packed {
      logic [2:0] out_port;
      logic [2:0] action;
      logic       enable_level;
      logic       timer_active;
      logic       last;
   } pfrc_rsp_type;

   // per port state held in the RAM; pending lives in flops
   typedef struct packed {
      logic        port_on;
      logic        tripped;
      logic        warned;
      logic [7:0]  retry_count;
      logic [31:0] retry_deadline;
   } pfrc_entry_type;

   localparam int ENTRY_W = $bits(pfrc_entry_type);

   typedef struct packed {
      logic       valid;
      logic [2:0] port;
      logic [2:0] action;
      logic       level;
   } pfrc_result_type;

endpackage

// ----- hw/rtl/pfrc_ram.sv -----
// pfrc_ram: generic one write port, one read port RAM with registered read data.
// No dependencies.
module pfrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/pfrc_port_update.sv -----
// pfrc_port_update: read-modify-write logic for one port entry per cycle.
// Depends on pfrc_pkg.
module pfrc_port_update (
   input  logic [2:0]               operation,
   input  logic                     turn_on,
   input  logic                     fuse_ok,
   input  logic                     active_high,
   input  logic [31:0]              now_ms,
   input  logic [7:0]               retry_limit,
   input  logic [15:0]              retry_interval,
   input  logic [2:0]               port,
   input  pfrc_pkg::pfrc_entry_type entry_rd,
   input  logic                     pending_rd,
   output pfrc_pkg::pfrc_entry_type entry_wr,
   output logic                     pending_wr,
   output pfrc_pkg::pfrc_result_type result
);
   import pfrc_pkg::*;

   logic [32:0] settle_time;
   logic        settled;
   logic        deadline_due;
   logic [31:0] base_time;
   logic [32:0] next_deadline;

   assign settle_time   = {1'b0, entry_rd.retry_deadline} + 33'(SETTLE_MS);
   assign settled       = {1'b0, now_ms} > settle_time;
   assign deadline_due  = now_ms > entry_rd.retry_deadline;
   assign base_time     = (entry_rd.retry_count == 8'd0) ? now_ms : entry_rd.retry_deadline;
   assign next_deadline = {1'b0, base_time} + {17'd0, retry_interval};

   always_comb begin
      entry_wr      = entry_rd;
      pending_wr    = pending_rd;
      result        = '0;
      result.port   = port;
      case (operation)
         OP_FAULT: begin
            if (entry_rd.port_on && !entry_rd.tripped) begin
               entry_wr.tripped = 1'b1;
               if (entry_rd.retry_count < retry_limit) begin
                  pending_wr = 1'b1;
               end else if (!entry_rd.warned) begin
                  entry_wr.warned = 1'b1;
                  result.valid    = 1'b1;
                  result.action   = ACT_FAULT_WARNING;
               end
            end
         end
         OP_TICK: begin
            if (pending_rd) begin
               if (fuse_ok) begin
                  if (settled) begin
                     entry_wr.retry_count = 8'd0;
                     pending_wr           = 1'b0;
                     result.valid         = 1'b1;
                     result.action        = ACT_RETRY_CLEARED;
                  end
               end else if (entry_rd.retry_count > retry_limit) begin
                  pending_wr = 1'b0;
                  if (!entry_rd.warned) begin
                     entry_wr.warned = 1'b1;
                     result.valid    = 1'b1;
                     result.action   = ACT_FAULT_WARNING;
                  end
               end else if (entry_rd.retry_count == 8'd0 || deadline_due) begin
                  entry_wr.tripped        = 1'b0;
                  entry_wr.retry_deadline = next_deadline[32] ? 32'hFFFF_FFFF
                                                              : next_deadline[31:0];
                  if (entry_rd.retry_count != 8'hFF) begin
                     entry_wr.retry_count = entry_rd.retry_count + 8'd1;
                  end
                  result.valid  = 1'b1;
                  result.action = ACT_RETRY_PULSE;
                  result.level  = active_high;
               end
            end
         end
         OP_ENABLE_ALL: begin
            entry_wr.port_on = 1'b1;
            entry_wr.tripped = 1'b0;
            if (fuse_ok) begin
               entry_wr.warned      = 1'b0;
               entry_wr.retry_count = 8'd0;
            end
         end
         OP_DISABLE_ALL: begin
            entry_wr.port_on = 1'b0;
         end
         OP_SET_PORT: begin
            entry_wr.tripped     = 1'b0;
            entry_wr.port_on     = turn_on;
            entry_wr.warned      = 1'b0;
            entry_wr.retry_count = 8'd0;
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- hw/rtl/pfrc_result_queue.sv -----
// pfrc_result_queue: small FIFO that collects the result items of one input item.
// Depends on pfrc_pkg.
module pfrc_result_queue #(
   parameter int DEPTH = pfrc_pkg::MAX_RESULTS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pfrc_pkg::pfrc_result_type       push,
   input  logic                            pop,
   output pfrc_pkg::pfrc_result_type       head,
   output logic [$clog2(DEPTH + 1)-1:0]    count
);
   import pfrc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pfrc_result_type   entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      nxt = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
      return nxt;
   endfunction

   always_comb begin
      wr_ptr_in = push.valid ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push.valid) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push;
      end
   end

   assign head  = entry_ff[rd_ptr_ff];
   assign count = count_ff;

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> count_ff != CNT_W'(DEPTH))
      else $error("result queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("result queue pop while empty");

   a_fill_then_drain: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !pop)
      else $error("result queue push and pop in one cycle");
`endif

endmodule

// ----- hw/rtl/port_fuse_retry_controller_unit.sv -----
// Port fuse retry controller top level; uses pfrc_pkg, pfrc_ram, pfrc_port_update and
// pfrc_result_queue. Per port state (on, tripped, warned, retry count, deadline) sits in
// a small RAM; valid bits make unwritten entries read as zero, so no clearing pass runs.
// One item is handled at a time: the accept cycle, then a scan that reads one port per
// cycle and writes it back in the following cycle, then a drain that offers the queued
// result items one at a time (at least one). A retry tick, enable all or disable all
// scans all NUM_PORTS ports (at most 8); a fault event whose fuse reads bad and a set port
// on a valid port touch one entry; other items skip the scan. The single RAM read port
// sets the scan length. All results of an item are queued before the first is offered, so
// timer_active already reflects the state left by the item.
module port_fuse_retry_controller_unit #(
   parameter int NUM_PORTS = pfrc_pkg::NUM_PORTS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  pfrc_pkg::pfrc_req_type                req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output pfrc_pkg::pfrc_rsp_type                rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [pfrc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [pfrc_pkg::CSR_DATA_W-1:0]       csr_wr_data
);
   import pfrc_pkg::*;

   localparam int NPORTS  = (NUM_PORTS < MAX_PORTS) ? NUM_PORTS : MAX_PORTS;
   localparam int IDX_W   = (NPORTS > 1) ? $clog2(NPORTS) : 1;
   localparam int CNT_W   = IDX_W + 1;
   localparam int Q_CNT_W = $clog2(MAX_RESULTS + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_DRAIN} state_type;

   state_type         state_ff, state_in;
   pfrc_req_type      item_ff, item_in;
   logic [CNT_W-1:0]  issue_ff, issue_in;
   logic [CNT_W-1:0]  end_ff, end_in;
   logic              s1_valid_ff, s1_valid_in;
   logic [IDX_W-1:0]  s1_idx_ff, s1_idx_in;
   logic [NPORTS-1:0] valid_ff, valid_in;
   logic [NPORTS-1:0] pending_ff, pending_in;

   logic [7:0]        limit_ff;
   logic [15:0]       interval_ff;
   logic [7:0]        ok_levels_ff;
   logic [7:0]        active_high_ff;

   logic              req_accept;
   logic              rsp_accept;
   logic              port_ok;
   logic              fuse_bad_req;
   logic              ah_req;

   logic              ram_rd_en;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic              ram_wr_en;
   logic [ENTRY_W-1:0] ram_rd_data;

   logic [2:0]        s1_port;
   pfrc_entry_type    entry_rd;
   pfrc_entry_type    entry_wr;
   logic              upd_pending;
   pfrc_result_type   upd_result;

   pfrc_result_type   push;
   logic              pop;
   pfrc_result_type   q_head;
   logic [Q_CNT_W-1:0] q_count;
   logic              q_empty;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (state_ff == ST_DRAIN);
   assign rsp_accept = rsp_valid && !rsp_stall;

   assign port_ok      = {1'b0, req_data.port} < 4'(NPORTS);
   assign fuse_bad_req = req_data.fuse_levels[req_data.port] != ok_levels_ff[req_data.port];
   assign ah_req       = active_high_ff[req_data.port];

   assign ram_rd_en   = (state_ff == ST_SWEEP) && (issue_ff < end_ff);
   assign ram_rd_addr = issue_ff[IDX_W-1:0];
   assign ram_wr_en   = s1_valid_ff;

   assign s1_port  = 3'(s1_idx_ff);
   assign entry_rd = valid_ff[s1_idx_ff] ? pfrc_entry_type'(ram_rd_data) : '0;

   pfrc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NPORTS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_idx_ff),
      .wr_data (ENTRY_W'(entry_wr)),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   pfrc_port_update u_port_update (
      .operation      (item_ff.operation),
      .turn_on        (item_ff.turn_on),
      .fuse_ok        (item_ff.fuse_levels[s1_port] == ok_levels_ff[s1_port]),
      .active_high    (active_high_ff[s1_port]),
      .now_ms         (item_ff.now_ms),
      .retry_limit    (limit_ff),
      .retry_interval (interval_ff),
      .port           (s1_port),
      .entry_rd       (entry_rd),
      .pending_rd     (pending_ff[s1_idx_ff]),
      .entry_wr       (entry_wr),
      .pending_wr     (upd_pending),
      .result         (upd_result)
   );

   pfrc_result_queue #(
      .DEPTH (MAX_RESULTS)
   ) u_result_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (q_head),
      .count (q_count)
   );

   assign q_empty = (q_count == '0);

   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      issue_in    = ram_rd_en ? issue_ff + CNT_W'(1) : issue_ff;
      end_in      = end_ff;
      s1_valid_in = ram_rd_en;
      s1_idx_in   = ram_rd_addr;
      valid_in    = valid_ff;
      pending_in  = pending_ff;
      push        = '0;
      pop         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               item_in  = req_data;
               issue_in = '0;
               end_in   = CNT_W'(NPORTS);
               state_in = ST_DRAIN;
               case (req_data.operation)
                  OP_FAULT: begin
                     if (port_ok && fuse_bad_req) begin
                        push.valid  = 1'b1;
                        push.port   = req_data.port;
                        push.action = ACT_FORCE_OFF;
                        push.level  = ~ah_req;
                        issue_in    = CNT_W'(req_data.port);
                        end_in      = CNT_W'(req_data.port) + CNT_W'(1);
                        state_in    = ST_SWEEP;
                     end
                  end
                  OP_TICK: begin
                     state_in = ST_SWEEP;
                  end
                  OP_ENABLE_ALL: begin
                     push.valid  = 1'b1;
                     push.action = ACT_ALL_ON;
                     state_in    = ST_SWEEP;
                  end
                  OP_DISABLE_ALL: begin
                     push.valid  = 1'b1;
                     push.action = ACT_ALL_OFF;
                     state_in    = ST_SWEEP;
                  end
                  OP_SET_PORT: begin
                     if (port_ok) begin
                        push.valid  = 1'b1;
                        push.port   = req_data.port;
                        push.action = ACT_DRIVE_SET;
                        push.level  = ah_req ? req_data.turn_on : ~req_data.turn_on;
                        issue_in    = CNT_W'(req_data.port);
                        end_in      = CNT_W'(req_data.port) + CNT_W'(1);
                        state_in    = ST_SWEEP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            if (s1_valid_ff) begin
               valid_in[s1_idx_ff]   = 1'b1;
               pending_in[s1_idx_ff] = upd_pending;
               push                  = upd_result;
               if (!ram_rd_en) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (rsp_accept) begin
               pop = !q_empty;
               if (q_count <= Q_CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         s1_valid_ff    <= 1'b0;
         valid_ff       <= '0;
         pending_ff     <= '0;
         limit_ff       <= RETRY_LIMIT_RST;
         interval_ff    <= RETRY_INTERVAL_RST;
         ok_levels_ff   <= FUSE_OK_LEVELS_RST;
         active_high_ff <= ENABLE_AH_RST;
      end else begin
         state_ff    <= state_in;
         s1_valid_ff <= s1_valid_in;
         valid_ff    <= valid_in;
         pending_ff  <= pending_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_RETRY_LIMIT:    limit_ff       <= csr_wr_data[7:0];
               CSR_RETRY_INTERVAL: interval_ff    <= csr_wr_data;
               CSR_FUSE_OK_LEVELS: ok_levels_ff   <= csr_wr_data[7:0];
               CSR_ENABLE_AH:      active_high_ff <= csr_wr_data[7:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      issue_ff  <= issue_in;
      end_ff    <= end_in;
      s1_idx_ff <= s1_idx_in;
   end

   // empty queue in drain means the item produced nothing: report a single none
   always_comb begin
      rsp_data              = '0;
      rsp_data.timer_active = |pending_ff;
      rsp_data.last         = (q_count <= Q_CNT_W'(1));
      if (!q_empty) begin
         rsp_data.out_port     = q_head.port;
         rsp_data.action       = q_head.action;
         rsp_data.enable_level = q_head.level;
      end else begin
         rsp_data.action = ACT_NONE;
      end
   end

`ifndef SYNTHESIS
   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted while results are offered");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.last) |=> !rsp_valid)
      else $error("result offered after the last item of an input");

   a_pending_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_SWEEP) |=> $stable(pending_ff))
      else $error("pending changed outside the port scan");

   a_no_rmw_overlap: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (!ram_rd_en || ram_rd_addr != s1_idx_ff))
      else $error("read and write back of the same entry overlap");
`endif

endmodule
